@@ rtl/core/cbp_pkg.sv @@
package cbp_pkg;

  localparam int MAX_DIM = 4096;
  localparam int BORDER_PIXELS = 2;
  localparam int NUM_BARS = 8;

  localparam int COORD_W = 12;
  localparam int DIM_W = 13;
  localparam int SHIFT_W = 5;
  localparam int BITS_W = 4;
  localparam int PIXEL_W = 32;
  localparam int BAR_W = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 13;
  // column * NUM_BARS and k * width both fit here
  localparam int SCALED_W = COORD_W + BAR_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PANEL_WIDTH  = 3'd0,
    REG_PANEL_HEIGHT = 3'd1,
    REG_RED_SHIFT    = 3'd2,
    REG_RED_BITS     = 3'd3,
    REG_GREEN_SHIFT  = 3'd4,
    REG_GREEN_BITS   = 3'd5,
    REG_BLUE_SHIFT   = 3'd6,
    REG_BLUE_BITS    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row_number;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_word;
    logic [BAR_W-1:0]   bar_number;
    logic               on_border;
  } out_item_t;

  // every channel of the bar palette is either 0 or 255: one flag per channel, {r,g,b}
  typedef logic [2:0] rgb_flags_t;

  localparam rgb_flags_t COLOUR_TABLE [NUM_BARS] = '{
    3'b100,  // red
    3'b010,  // green
    3'b001,  // blue
    3'b110,  // yellow
    3'b011,  // cyan
    3'b101,  // magenta
    3'b111,  // white
    3'b000   // black
  };

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    clamp_dim = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
  endfunction

  // low <bits> bits of 255, count saturated at 8
  function automatic logic [7:0] keep_mask(input logic [BITS_W-1:0] bits);
    logic [8:0] ones;
    ones = (9'd1 << bits) - 9'd1;
    keep_mask = (bits >= BITS_W'(8)) ? 8'hFF : ones[7:0];
  endfunction

endpackage

@@ rtl/core/colour_bar_pattern_pixel.sv @@
// Colour bar test pattern, one pixel per clock while the output is not stalled.
//
// Input channel (in_valid/in_ready/in_data) carries a pixel coordinate; the
// output channel (out_valid/out_ready/out_data) returns one word per input:
// the packed pixel, the bar index and the border flag. Eight equal vertical
// bars, a two-pixel white frame, channels truncated and placed per the
// config registers.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// write registers only while no pixel is in flight.
// Three register stages lie between input accept and out_valid (bar
// compares and border test, colour and channel masks, field placement).
// Throughput: one pixel per clock while out_ready holds, set by the stage registers.
// Reset (rst, synchronous) empties the pipe and loads 240x240 RGB888 layout.
// When the receiver stalls, the held word stays on out_data and the earlier
// stages keep filling; in_ready drops only once every stage holds a word.
module colour_bar_pattern_pixel
  import cbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [DIM_W-1:0]   panel_width, panel_height;
  logic [SHIFT_W-1:0] red_shift, green_shift, blue_shift;
  logic [BITS_W-1:0]  red_bits, green_bits, blue_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= DIM_W'(240);
      panel_height <= DIM_W'(240);
      red_shift    <= SHIFT_W'(16);
      red_bits     <= BITS_W'(8);
      green_shift  <= SHIFT_W'(8);
      green_bits   <= BITS_W'(8);
      blue_shift   <= SHIFT_W'(0);
      blue_bits    <= BITS_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PANEL_WIDTH:  panel_width  <= cfg_data;
        REG_PANEL_HEIGHT: panel_height <= cfg_data;
        REG_RED_SHIFT:    red_shift    <= cfg_data[SHIFT_W-1:0];
        REG_RED_BITS:     red_bits     <= cfg_data[BITS_W-1:0];
        REG_GREEN_SHIFT:  green_shift  <= cfg_data[SHIFT_W-1:0];
        REG_GREEN_BITS:   green_bits   <= cfg_data[BITS_W-1:0];
        REG_BLUE_SHIFT:   blue_shift   <= cfg_data[SHIFT_W-1:0];
        REG_BLUE_BITS:    blue_bits    <= cfg_data[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage advance chain: a stage loads when it is empty or its word moves on
  logic v1, v2, v3;
  logic ready1, ready2, ready3;

  assign ready3   = !v3 || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // ---- stage 1: bar thresholds and border test
  logic [DIM_W-1:0]        w_eff, h_eff;
  logic [SCALED_W-1:0]     x_scaled;
  logic [NUM_BARS-2:0]     bar_ge_next;
  logic                    border_next;
  logic [NUM_BARS-2:0]     bar_ge1;
  logic                    border1;

  assign w_eff    = clamp_dim(panel_width);
  assign h_eff    = clamp_dim(panel_height);
  assign x_scaled = SCALED_W'(in_data.column) << BAR_W;

  // bar >= k exactly when column*8 >= k*width
  always_comb begin
    for (int k = 1; k < NUM_BARS; k++) begin
      bar_ge_next[k-1] = x_scaled >= SCALED_W'(SCALED_W'(w_eff) * SCALED_W'(k));
    end
  end

  assign border_next =
      (in_data.column < COORD_W'(BORDER_PIXELS)) ||
      (DIM_W'(in_data.column) + DIM_W'(BORDER_PIXELS) >= w_eff) ||
      (in_data.row_number < COORD_W'(BORDER_PIXELS)) ||
      (DIM_W'(in_data.row_number) + DIM_W'(BORDER_PIXELS) >= h_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      bar_ge1 <= bar_ge_next;
      border1 <= border_next;
    end
  end

  // ---- stage 2: bar index, palette and channel masks
  logic [BAR_W-1:0] bar_next;
  rgb_flags_t       rgb_next;
  logic [BAR_W-1:0] bar2;
  logic             border2;
  logic [7:0]       red_keep, green_keep, blue_keep;

  // thresholds are monotonic, so the bar is the count of passed ones
  always_comb begin
    bar_next = '0;
    for (int k = 0; k < NUM_BARS - 1; k++) begin
      if (bar_ge1[k]) begin
        bar_next = BAR_W'(k + 1);
      end
    end
  end

  assign rgb_next = COLOUR_TABLE[bar_next] | {3{border1}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      bar2       <= bar_next;
      border2    <= border1;
      red_keep   <= rgb_next[2] ? keep_mask(red_bits) : 8'h00;
      green_keep <= rgb_next[1] ? keep_mask(green_bits) : 8'h00;
      blue_keep  <= rgb_next[0] ? keep_mask(blue_bits) : 8'h00;
    end
  end

  // ---- stage 3: place fields, bits past the top of the word drop off
  logic [PIXEL_W-1:0] pixel_next;

  assign pixel_next = (PIXEL_W'(red_keep) << red_shift) |
                      (PIXEL_W'(green_keep) << green_shift) |
                      (PIXEL_W'(blue_keep) << blue_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      out_data.pixel_word <= pixel_next;
      out_data.bar_number <= bar2;
      out_data.on_border  <= border2;
    end
  end

  assign out_valid = v3;

endmodule

@@ rtl/core/cbp_checker.sv @@
module cbp_checker
  import cbp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      cfg_ready
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  // a stalled output word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // an empty output stage means nothing upstream can be blocked
  a_ready_when_drained: assert property (@(posedge clk) !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  // config port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind colour_bar_pattern_pixel cbp_checker u_cbp_checker (.*);
